// ----- rtl/prcf_pkg.sv -----
// prcf_pkg: shared constants, widths, register codes and the atan table
// for the pitch/roll complementary filter
// no dependencies
package prcf_pkg;

  // angle format and cordic length
  localparam int CORDIC_STEPS    = 16;
  localparam int ANGLE_FRAC_BITS = 16;
  localparam int ATAN_LEN        = 24;
  localparam int CORDIC_FRAC     = 24;
  localparam int CORDIC_RUN      = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam int ATAN_IDX_W      = 5;

  // stored angle: +-360 deg plus cordic headroom
  localparam int ANGLE_W = ANGLE_FRAC_BITS + 10;
  // gyro increment, signed
  localparam int DELTA_W = ANGLE_FRAC_BITS + 17;
  // cordic x/y datapath and q24 angle accumulator
  localparam int CORD_W  = 28;
  localparam int Z_W     = 34;
  localparam int Z_SH    = CORDIC_FRAC - ANGLE_FRAC_BITS;
  localparam longint Z_HALF = 64'd1 << (Z_SH - 1);
  localparam longint Z_90   = 64'd90 << CORDIC_FRAC;

  // gyro product |rate*scale| and the serial multiply/divide
  localparam int MAG_W    = 40;
  localparam int US_W     = 20;
  localparam int NUM_W    = 59;
  localparam longint DIV_D    = 64'd1000000 << (CORDIC_FRAC - ANGLE_FRAC_BITS);
  localparam longint DIV_HALF = DIV_D / 2;
  localparam int REM_W    = $clog2(DIV_D) + 1;
  localparam int GCNT_W   = $clog2(NUM_W);

  // blend
  localparam int W_W        = 17;
  localparam int WEIGHT_ONE = 65536;
  localparam int BL_W       = DELTA_W + 1;
  localparam int PROD_W     = BL_W + W_W + 1;
  localparam longint ANGLE_LIM = 64'd360 << ANGLE_FRAC_BITS;

  // output rounding to 8 fraction bits
  localparam int OUT_SH   = ANGLE_FRAC_BITS - 8;
  localparam longint OUT_HALF = (OUT_SH > 0) ? (64'd1 << (OUT_SH - 1)) : 64'd0;
  localparam int OUT_W    = 18;

  // ports
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RATE_SCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_WEIGHT = 2'd1;

  localparam logic [23:0]    RATE_SCALE_RST  = 24'd128070;
  localparam logic [W_W-1:0] GYRO_WEIGHT_RST = 17'd62259;

  // atan(2^-i) in degrees, 24 fraction bits
  function automatic logic [30:0] atan_q24(input logic [ATAN_IDX_W-1:0] idx);
    logic [30:0] v;
    unique case (idx)
      5'd0:  v = 31'd754974720;
      5'd1:  v = 31'd445687602;
      5'd2:  v = 31'd235489088;
      5'd3:  v = 31'd119537938;
      5'd4:  v = 31'd60000934;
      5'd5:  v = 31'd30029717;
      5'd6:  v = 31'd15018523;
      5'd7:  v = 31'd7509720;
      5'd8:  v = 31'd3754917;
      5'd9:  v = 31'd1877466;
      5'd10: v = 31'd938734;
      5'd11: v = 31'd469367;
      5'd12: v = 31'd234684;
      5'd13: v = 31'd117342;
      5'd14: v = 31'd58671;
      5'd15: v = 31'd29335;
      5'd16: v = 31'd14668;
      5'd17: v = 31'd7334;
      5'd18: v = 31'd3667;
      5'd19: v = 31'd1833;
      5'd20: v = 31'd917;
      5'd21: v = 31'd458;
      5'd22: v = 31'd229;
      5'd23: v = 31'd115;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/prcf_cordic.sv -----
// prcf_cordic: vectoring cordic, atan2(y, x) in degrees, one rotation per cycle
// depends on prcf_pkg
module prcf_cordic import prcf_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic signed [CORD_W-1:0]   y_in,
  input  logic signed [CORD_W-1:0]   x_in,
  output logic                       done,
  output logic signed [ANGLE_W-1:0]  angle
);

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_ROT  = 2'd1;
  localparam logic [1:0] C_RND  = 2'd2;

  localparam logic signed [Z_W-1:0] Z90_C   = Z_W'(Z_90);
  localparam logic signed [Z_W-1:0] ZHALF_C = Z_W'(Z_HALF);
  localparam logic [ATAN_IDX_W-1:0] IDX_LAST = ATAN_IDX_W'(CORDIC_RUN - 1);

  logic [1:0]                state_r, state_nxt;
  logic [ATAN_IDX_W-1:0]     idx_r, idx_nxt;
  logic signed [CORD_W-1:0]  x_r, x_nxt, y_r, y_nxt;
  logic signed [Z_W-1:0]     z_r, z_nxt;
  logic                      zero_r, zero_nxt;
  logic                      done_r, done_nxt;
  logic signed [ANGLE_W-1:0] angle_r, angle_nxt;

  logic signed [CORD_W-1:0]  xs, ys;
  logic signed [Z_W-1:0]     tbl, z_rnd;

  assign xs    = x_r >>> idx_r;
  assign ys    = y_r >>> idx_r;
  assign tbl   = $signed({3'b000, atan_q24(idx_r)});
  assign z_rnd = (z_r + ZHALF_C) >>> Z_SH;

  // sequencer: load with quadrant fold, rotate, round
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    zero_nxt  = zero_r;
    done_nxt  = 1'b0;
    angle_nxt = angle_r;
    unique case (state_r)
      C_IDLE: begin
        if (start) begin
          zero_nxt  = (x_in == '0) && (y_in == '0);
          idx_nxt   = '0;
          state_nxt = C_ROT;
          if (x_in < 0) begin
            if (y_in >= 0) begin
              x_nxt = y_in;
              y_nxt = -x_in;
              z_nxt = Z90_C;
            end else begin
              x_nxt = -y_in;
              y_nxt = x_in;
              z_nxt = -Z90_C;
            end
          end else begin
            x_nxt = x_in;
            y_nxt = y_in;
            z_nxt = '0;
          end
        end
      end
      C_ROT: begin
        if (y_r > 0) begin
          x_nxt = x_r + ys;
          y_nxt = y_r - xs;
          z_nxt = z_r + tbl;
        end else begin
          x_nxt = x_r - ys;
          y_nxt = y_r + xs;
          z_nxt = z_r - tbl;
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == IDX_LAST) begin
          state_nxt = C_RND;
        end
      end
      C_RND: begin
        angle_nxt = zero_r ? '0 : ANGLE_W'(z_rnd);
        done_nxt  = 1'b1;
        state_nxt = C_IDLE;
      end
      default: begin
        state_nxt = C_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    z_r     <= z_nxt;
    zero_r  <= zero_nxt;
    angle_r <= angle_nxt;
  end

  assign done  = done_r;
  assign angle = angle_r;

endmodule

// ----- rtl/prcf_gyro.sv -----
// prcf_gyro: gyro angle increment, rate*scale*us / (1e6 * 2^(24-frac)),
// shift-add multiply one bit a cycle, restoring divide one bit a cycle
// depends on prcf_pkg
module prcf_gyro import prcf_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic signed [15:0]         rate,
  input  logic [23:0]                scale,
  input  logic [US_W-1:0]            us,
  output logic                       done,
  output logic signed [DELTA_W-1:0]  delta
);

  localparam logic [2:0] G_IDLE = 3'd0;
  localparam logic [2:0] G_MUL  = 3'd1;
  localparam logic [2:0] G_RND  = 3'd2;
  localparam logic [2:0] G_DIV  = 3'd3;
  localparam logic [2:0] G_SGN  = 3'd4;

  localparam logic [REM_W-1:0] DIV_C  = REM_W'(DIV_D);
  localparam logic [NUM_W-1:0] HALF_C = NUM_W'(DIV_HALF);
  localparam logic [GCNT_W-1:0] MUL_LAST = GCNT_W'(US_W - 1);
  localparam logic [GCNT_W-1:0] DIV_LAST = GCNT_W'(NUM_W - 1);

  logic [2:0]               state_r, state_nxt;
  logic [GCNT_W-1:0]        cnt_r, cnt_nxt;
  logic [MAG_W-1:0]         mag_r, mag_nxt;
  logic                     neg_r, neg_nxt;
  logic [US_W-1:0]          us_r, us_nxt;
  logic [NUM_W-1:0]         num_r, num_nxt;
  logic [REM_W-1:0]         rem_r, rem_nxt;
  logic                     done_r, done_nxt;
  logic signed [DELTA_W-1:0] delta_r, delta_nxt;

  logic signed [MAG_W:0]    prod, prod_abs;
  logic [REM_W-1:0]         rem_sh;
  logic                     ge;
  logic signed [DELTA_W-1:0] qmag;

  assign prod     = rate * $signed({1'b0, scale});
  assign prod_abs = prod[MAG_W] ? -prod : prod;
  assign rem_sh   = {rem_r[REM_W-2:0], num_r[NUM_W-1]};
  assign ge       = rem_sh >= DIV_C;
  assign qmag     = $signed({1'b0, num_r[DELTA_W-2:0]});

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    us_nxt    = us_r;
    num_nxt   = num_r;
    rem_nxt   = rem_r;
    done_nxt  = 1'b0;
    delta_nxt = delta_r;
    unique case (state_r)
      G_IDLE: begin
        if (start) begin
          mag_nxt   = prod_abs[MAG_W-1:0];
          neg_nxt   = prod[MAG_W];
          us_nxt    = us;
          num_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = G_MUL;
        end
      end
      // msb-first shift-add over the microsecond count
      G_MUL: begin
        num_nxt = {num_r[NUM_W-2:0], 1'b0}
                  + (us_r[US_W-1] ? {{(NUM_W-MAG_W){1'b0}}, mag_r} : '0);
        us_nxt  = {us_r[US_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == MUL_LAST) begin
          state_nxt = G_RND;
        end
      end
      G_RND: begin
        num_nxt   = num_r + HALF_C;
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = G_DIV;
      end
      // restoring divide, quotient shifts in behind the dividend
      G_DIV: begin
        rem_nxt = ge ? (rem_sh - DIV_C) : rem_sh;
        num_nxt = {num_r[NUM_W-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = G_SGN;
        end
      end
      G_SGN: begin
        delta_nxt = neg_r ? -qmag : qmag;
        done_nxt  = 1'b1;
        state_nxt = G_IDLE;
      end
      default: begin
        state_nxt = G_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= G_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    mag_r   <= mag_nxt;
    neg_r   <= neg_nxt;
    us_r    <= us_nxt;
    num_r   <= num_nxt;
    rem_r   <= rem_nxt;
    delta_r <= delta_nxt;
  end

  assign done  = done_r;
  assign delta = delta_r;

endmodule

// ----- rtl/pitch_roll_complementary_filter.sv -----
// pitch_roll_complementary_filter: top level, tilt from accel via cordic,
// gyro integration and weighted blend of the stored pitch and roll
// depends on prcf_pkg, prcf_cordic, prcf_gyro
//
//   channel | dir | beat fields (low bits first)
//   in_     | in  | accel_x, accel_y, accel_z, gyro_x, gyro_y, elapsed_us
//   out_    | out | pitch_deg, roll_deg
//   cfg_    | in  | index 0 rate_scale, index 1 gyro_weight
//
// one sample at a time; the time from input beat to result beat is set by
// the two gyro units (serial multiply and serial divide), which run beside
// the 24-step square root and two cordic runs
// reset (rst_n low at a clock edge) clears the stored angles to zero and
// loads the register defaults; a held result stalls only the final stage,
// the next sample is taken as soon as the result sits in the output register
module pitch_roll_complementary_filter import prcf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // accel_x[15:0] accel_y[31:16] accel_z[47:32] gyro_x[63:48] gyro_y[79:64]
  // elapsed_us[99:80], zero fill above
  input  logic [IN_DATA_W-1:0]   in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // pitch_deg[17:0] roll_deg[35:18], zero fill above
  output logic [OUT_DATA_W-1:0]  out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam logic [3:0] T_IDLE = 4'd0;
  localparam logic [3:0] T_SQA  = 4'd1;
  localparam logic [3:0] T_SQB  = 4'd2;
  localparam logic [3:0] T_SQRT = 4'd3;
  localparam logic [3:0] T_CP   = 4'd4;
  localparam logic [3:0] T_CR   = 4'd5;
  localparam logic [3:0] T_GW   = 4'd6;
  localparam logic [3:0] T_B1   = 4'd7;
  localparam logic [3:0] T_B2   = 4'd8;
  localparam logic [3:0] T_B3   = 4'd9;
  localparam logic [3:0] T_OUT  = 4'd10;

  localparam int SQ_STEPS = 24;
  localparam logic [4:0] SQ_LAST = 5'(SQ_STEPS - 1);
  localparam logic [W_W-1:0] W_ONE = W_W'(WEIGHT_ONE);
  localparam logic signed [PROD_W:0] LIM_C  = (PROD_W+1)'(ANGLE_LIM);
  localparam logic signed [PROD_W:0] BL_RND = (PROD_W+1)'(32768);
  localparam logic signed [ANGLE_W-1:0] OHALF_C = ANGLE_W'(OUT_HALF);

  // configuration registers
  logic [23:0]    scale_r;
  logic [W_W-1:0] weight_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= RATE_SCALE_RST;
      weight_r <= GYRO_WEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RATE_SCALE:  scale_r  <= cfg_wdata[23:0];
        REG_GYRO_WEIGHT: weight_r <= cfg_wdata[W_W-1:0];
        default: ;
      endcase
    end
  end

  // state and control
  logic [3:0]  state_r, state_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        side_r, side_nxt;
  logic        cstart_r, cstart_nxt;
  logic        gstart_r, gstart_nxt;
  logic [1:0]  gdone_r, gdone_nxt;
  logic        ovalid_r, ovalid_nxt;

  // payload
  logic signed [15:0]        ax_r, ay_r, az_r, gx_r, gy_r;
  logic [US_W-1:0]           us_r;
  logic [31:0]               sq_r, sq_nxt;
  logic [47:0]               sqn_r, sqn_nxt;
  logic [26:0]               srem_r, srem_nxt;
  logic [23:0]               root_r, root_nxt;
  logic signed [ANGLE_W-1:0] accp_r, accp_nxt, accr_r, accr_nxt;
  logic signed [ANGLE_W-1:0] pitch_r, pitch_nxt, roll_r, roll_nxt;
  logic signed [PROD_W-1:0]  p1_r, p1_nxt, p2_r, p2_nxt;
  logic [OUT_DATA_W-1:0]     odata_r, odata_nxt;

  // unit links
  logic                      cdone, gp_done, gr_done;
  logic signed [ANGLE_W-1:0] cangle;
  logic signed [CORD_W-1:0]  cy, cx;
  logic signed [DELTA_W-1:0] dp, dr;

  // square and root step
  logic signed [15:0] sq_op;
  logic signed [31:0] sq_prod;
  logic [26:0]        rem_sh, trial;

  assign sq_op   = (state_r == T_SQA) ? ay_r : az_r;
  assign sq_prod = sq_op * sq_op;
  assign rem_sh  = {srem_r[24:0], sqn_r[47:46]};
  assign trial   = {1'b0, root_r, 2'b01};

  // cordic operands: pitch uses (-ax*256, root), roll uses (ay, az)
  logic signed [CORD_W-1:0] ax_ext;
  assign ax_ext = CORD_W'(ax_r);
  assign cy = (state_r == T_CR) ? CORD_W'(ay_r) : -(ax_ext <<< 8);
  assign cx = (state_r == T_CR) ? CORD_W'(az_r) : $signed({{(CORD_W-24){1'b0}}, root_r});

  // blend multiplier, shared between the two weighted terms
  logic [W_W-1:0]            wc, wa;
  logic signed [W_W:0]       mop_a;
  logic signed [BL_W-1:0]    mop_b;
  logic signed [ANGLE_W-1:0] ang_sel, acc_sel;
  logic signed [DELTA_W-1:0] dlt_sel;
  logic signed [PROD_W:0]    bl_sum, bl_sh;
  logic signed [ANGLE_W-1:0] bl_res;

  assign wc      = (weight_r > W_ONE) ? W_ONE : weight_r;
  assign wa      = W_ONE - wc;
  assign ang_sel = side_r ? roll_r : pitch_r;
  assign acc_sel = side_r ? accr_r : accp_r;
  assign dlt_sel = side_r ? dr : dp;
  assign mop_a   = $signed({1'b0, (state_r == T_B1) ? wc : wa});
  assign mop_b   = (state_r == T_B1) ? (BL_W'(ang_sel) + BL_W'(dlt_sel)) : BL_W'(acc_sel);
  assign bl_sum  = (PROD_W+1)'(p1_r) + (PROD_W+1)'(p2_r) + BL_RND;
  assign bl_sh   = bl_sum >>> 16;
  always_comb begin
    priority if (bl_sh > LIM_C) begin
      bl_res = ANGLE_W'(LIM_C);
    end else if (bl_sh < -LIM_C) begin
      bl_res = ANGLE_W'(-LIM_C);
    end else begin
      bl_res = ANGLE_W'(bl_sh);
    end
  end

  // output rounding to 8 fraction bits
  logic signed [ANGLE_W-1:0] pitch_o, roll_o;
  assign pitch_o = (pitch_r + OHALF_C) >>> OUT_SH;
  assign roll_o  = (roll_r + OHALF_C) >>> OUT_SH;

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    side_nxt   = side_r;
    cstart_nxt = 1'b0;
    gstart_nxt = 1'b0;
    gdone_nxt  = gdone_r | {gr_done, gp_done};
    ovalid_nxt = ovalid_r && !out_tready;
    sq_nxt     = sq_r;
    sqn_nxt    = sqn_r;
    srem_nxt   = srem_r;
    root_nxt   = root_r;
    accp_nxt   = accp_r;
    accr_nxt   = accr_r;
    pitch_nxt  = pitch_r;
    roll_nxt   = roll_r;
    p1_nxt     = p1_r;
    p2_nxt     = p2_r;
    odata_nxt  = odata_r;
    unique case (state_r)
      T_IDLE: begin
        if (in_tvalid) begin
          gstart_nxt = 1'b1;
          gdone_nxt  = 2'b00;
          state_nxt  = T_SQA;
        end
      end
      T_SQA: begin
        sq_nxt    = 32'(sq_prod);
        state_nxt = T_SQB;
      end
      T_SQB: begin
        sqn_nxt   = {sq_r + 32'(sq_prod), 16'h0000};
        srem_nxt  = '0;
        root_nxt  = '0;
        cnt_nxt   = '0;
        state_nxt = T_SQRT;
      end
      // two radicand bits per cycle, one root bit
      T_SQRT: begin
        if (rem_sh >= trial) begin
          srem_nxt = rem_sh - trial;
          root_nxt = {root_r[22:0], 1'b1};
        end else begin
          srem_nxt = rem_sh;
          root_nxt = {root_r[22:0], 1'b0};
        end
        sqn_nxt = {sqn_r[45:0], 2'b00};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == SQ_LAST) begin
          cstart_nxt = 1'b1;
          state_nxt  = T_CP;
        end
      end
      T_CP: begin
        if (cdone) begin
          accp_nxt   = cangle;
          cstart_nxt = 1'b1;
          state_nxt  = T_CR;
        end
      end
      T_CR: begin
        if (cdone) begin
          accr_nxt  = cangle;
          state_nxt = T_GW;
        end
      end
      T_GW: begin
        if (gdone_r == 2'b11) begin
          side_nxt  = 1'b0;
          state_nxt = T_B1;
        end
      end
      T_B1: begin
        p1_nxt    = PROD_W'(mop_a) * PROD_W'(mop_b);
        state_nxt = T_B2;
      end
      T_B2: begin
        p2_nxt    = PROD_W'(mop_a) * PROD_W'(mop_b);
        state_nxt = T_B3;
      end
      T_B3: begin
        if (side_r) begin
          roll_nxt  = bl_res;
          state_nxt = T_OUT;
        end else begin
          pitch_nxt = bl_res;
          side_nxt  = 1'b1;
          state_nxt = T_B1;
        end
      end
      T_OUT: begin
        if (!ovalid_r || out_tready) begin
          odata_nxt  = {{(OUT_DATA_W-2*OUT_W){1'b0}}, roll_o[OUT_W-1:0], pitch_o[OUT_W-1:0]};
          ovalid_nxt = 1'b1;
          state_nxt  = T_IDLE;
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  // control state and stored angles
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= T_IDLE;
      cstart_r <= 1'b0;
      gstart_r <= 1'b0;
      gdone_r  <= 2'b00;
      ovalid_r <= 1'b0;
      pitch_r  <= '0;
      roll_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      cstart_r <= cstart_nxt;
      gstart_r <= gstart_nxt;
      gdone_r  <= gdone_nxt;
      ovalid_r <= ovalid_nxt;
      pitch_r  <= pitch_nxt;
      roll_r   <= roll_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    side_r  <= side_nxt;
    sq_r    <= sq_nxt;
    sqn_r   <= sqn_nxt;
    srem_r  <= srem_nxt;
    root_r  <= root_nxt;
    accp_r  <= accp_nxt;
    accr_r  <= accr_nxt;
    p1_r    <= p1_nxt;
    p2_r    <= p2_nxt;
    odata_r <= odata_nxt;
  end

  // input capture on the accepted beat
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      ax_r <= in_tdata[15:0];
      ay_r <= in_tdata[31:16];
      az_r <= in_tdata[47:32];
      gx_r <= in_tdata[63:48];
      gy_r <= in_tdata[79:64];
      us_r <= in_tdata[99:80];
    end
  end

  prcf_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cstart_r),
    .y_in  (cy),
    .x_in  (cx),
    .done  (cdone),
    .angle (cangle)
  );

  // pitch follows gyro y, roll follows gyro x
  prcf_gyro u_gyro_p (
    .clk   (clk),
    .rst_n (rst_n),
    .start (gstart_r),
    .rate  (gy_r),
    .scale (scale_r),
    .us    (us_r),
    .done  (gp_done),
    .delta (dp)
  );

  prcf_gyro u_gyro_r (
    .clk   (clk),
    .rst_n (rst_n),
    .start (gstart_r),
    .rate  (gx_r),
    .scale (scale_r),
    .us    (us_r),
    .done  (gr_done),
    .delta (dr)
  );

  assign in_tready  = (state_r == T_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

endmodule

// ----- rtl/prcf_checker.sv -----
// prcf_checker: port-level checks on the complementary filter top level
// depends on prcf_pkg; bound to pitch_roll_complementary_filter
module prcf_checker import prcf_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // a held result beat keeps its data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // one sample in flight: the beat after an accept is never taken at once
  a_one_sample: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a sample is in flight");

  // reset leaves no result and an open input
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("bad state after reset");

  // fill bits above the two angles stay zero
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DATA_W-1:36] == '0)
    else $error("result fill bits set");

endmodule

bind pitch_roll_complementary_filter prcf_checker u_prcf_checker (.*);

// ----- tb/testbench.sv -----
// testbench for pitch_roll_complementary_filter: directed and randomized imu samples
// checked against a bit-exact tilt/gyro/blend predictor in a scoreboard class
// depends on prcf_pkg and the rtl top level
`timescale 1ns / 1ps

module testbench;
  import prcf_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // accel_x, accel_y, accel_z, gyro_x, gyro_y, elapsed_us, zero fill
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // pitch_deg, roll_deg, zero fill
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  typedef struct {
    shortint     ax, ay, az, gx, gy;
    logic [19:0] us;
  } imu_sample_t;

  typedef struct {
    logic [17:0] pitch, roll;
  } tilt_out_t;

  // predictor of the filter state plus the queue of pending outputs
  class tilt_scoreboard;
    longint      pitch_q, roll_q;
    logic [23:0] scale;
    logic [16:0] weight;
    tilt_out_t   pending[$];
    int          errors;

    function void reset_state();
      pitch_q = 0;
      roll_q = 0;
      scale = RATE_SCALE_RST;
      weight = GYRO_WEIGHT_RST;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] val);
      if (idx == REG_RATE_SCALE) scale = val;
      else if (idx == REG_GYRO_WEIGHT) weight = val[16:0];
    endfunction

    function longint root_floor(longint n);
      longint res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >>> 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n = n - (res + bitv);
          res = (res >>> 1) + bitv;
        end else begin
          res = res >>> 1;
        end
        bitv = bitv >>> 2;
      end
      return res;
    endfunction

    // vectoring cordic, degrees with 16 fraction bits
    function longint tilt_atan2(longint y, longint x);
      longint z, t, xs, ys;
      longint tbl[24] = '{754974720, 445687602, 235489088, 119537938, 60000934,
        30029717, 15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
        117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        if (y >= 0) begin
          t = x; x = y; y = -t; z = 64'd90 << 24;
        end else begin
          t = x; x = -y; y = t; z = -(64'd90 << 24);
        end
      end
      for (int i = 0; i < 16; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys; y = y - xs; z = z + tbl[i];
        end else begin
          x = x - ys; y = y + xs; z = z - tbl[i];
        end
      end
      return (z + 128) >>> 8;
    endfunction

    // rate * scale * us / (2^8 * 1e6), rounded half away from zero
    function longint rate_step(longint rate, longint us);
      longint prod, q;
      logic [63:0] mag;
      prod = rate * longint'(scale);
      mag = (prod < 0) ? -prod : prod;
      mag = mag * us;
      q = (mag + 64'd128000000) / 64'd256000000;
      return (prod < 0) ? -q : q;
    endfunction

    function longint mix(longint ang, longint d, longint acc);
      longint w, v, lim;
      lim = longint'(360) << 16;
      w = (weight > 65536) ? 65536 : weight;
      v = w * (ang + d) + (65536 - w) * acc;
      v = (v + 32768) >>> 16;
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      return v;
    endfunction

    function void note_sample(imu_sample_t s);
      longint r, pa, ra;
      tilt_out_t e;
      r = root_floor((longint'(s.ay) * s.ay + longint'(s.az) * s.az) << 16);
      pa = tilt_atan2(-longint'(s.ax) * 256, r);
      ra = tilt_atan2(s.ay, s.az);
      pitch_q = mix(pitch_q, rate_step(s.gy, s.us), pa);
      roll_q = mix(roll_q, rate_step(s.gx, s.us), ra);
      e.pitch = 18'((pitch_q + 128) >>> 8);
      e.roll = 18'((roll_q + 128) >>> 8);
      pending.push_back(e);
    endfunction

    function void check_beat(logic [OUT_DATA_W-1:0] d);
      tilt_out_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output beat %h", d);
        return;
      end
      e = pending.pop_front();
      if (d[17:0] !== e.pitch || d[35:18] !== e.roll) begin
        errors++;
        if (errors <= 10)
          $display("pitch exp %h got %h, roll exp %h got %h",
                   e.pitch, d[17:0], e.roll, d[35:18]);
      end
    endfunction
  endclass

  tilt_scoreboard sb;
  int unsigned    cycle_count = 0;
  bit             sink_on = 1'b0;

  pitch_roll_complementary_filter dut (.*);

  always #4 clk = ~clk;

  // timeout watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 1500000) begin
      $display("pitch_roll_complementary_filter: mismatch");
      $finish;
    end
  end

  // output sink with random stalls
  initial begin
    int wait_n;
    forever begin
      @(posedge clk);
      if (sink_on) begin
        wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        repeat (wait_n) @(posedge clk);
        out_tready <= 1'b1;
        do @(posedge clk); while (!out_tvalid);
        sb.check_beat(out_tdata);
        out_tready <= 1'b0;
      end
    end
  end

  // one register write, then cfg_we low again before the task returns
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  // valid stays up across a zero gap so back-to-back beats need one update
  task automatic send_sample(imu_sample_t s, bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= {4'b0, s.us, s.gy, s.gx, s.az, s.ay, s.ax};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_sample(s);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic shortint pick16();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return shortint'($urandom_range(0, 600)) - 300;
      default: return shortint'($urandom);
    endcase
  endfunction

  function automatic imu_sample_t rand_sample();
    imu_sample_t s;
    s.ax = pick16(); s.ay = pick16(); s.az = pick16();
    s.gx = pick16(); s.gy = pick16();
    case ($urandom_range(0, 3))
      0: s.us = 20'($urandom);
      1: s.us = '1;
      default: s.us = 20'($urandom_range(0, 50000));
    endcase
    return s;
  endfunction

  initial begin
    imu_sample_t s;
    shortint     ext[4] = '{16'sh7fff, -16'sh8000, 0, 16'sh0001};
    logic [23:0] scales[4] = '{24'hffffff, 24'd0, 24'd128070, 24'd65536};
    logic [23:0] weights[4] = '{24'd65536, 24'd0, 24'd131071, 24'd62259};
    sb = new();
    sb.reset_state();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    sink_on = 1'b1;

    // directed: zero vectors, axis extremes, negative x with zero y
    for (int i = 0; i < 20; i++) begin
      s.ax = ext[i % 4]; s.ay = ext[(i / 4) % 4]; s.az = ext[(i + 1) % 4];
      s.gx = ext[(i + 2) % 4]; s.gy = ext[(i + 3) % 4];
      s.us = (i % 3 == 0) ? 20'hfffff : 20'(i * 1000);
      if (i == 0) begin
        s.ax = 0; s.ay = 0; s.az = 0;
      end
      if (i == 1) begin
        s.ay = 0; s.az = -16'sd500;
      end
      send_sample(s, 1'b0);
    end
    drain();

    // random phases across register settings, including an unused index
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_RATE_SCALE, scales[ph]);
      write_reg(REG_GYRO_WEIGHT, weights[ph]);
      write_reg(2'd3, 24'($urandom));
      for (int n = 0; n < 100; n++) send_sample(rand_sample(), ph == 2);
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("pitch_roll_complementary_filter: match");
    end else begin
      $display("pitch_roll_complementary_filter: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/prcf_pkg.sv
rtl/prcf_cordic.sv
rtl/prcf_gyro.sv
rtl/pitch_roll_complementary_filter.sv
rtl/prcf_checker.sv
tb/testbench.sv
